[design/byte_ring_fifo_core_macros.svh]
// assertion macros shared by the ring fifo rtl
// every macro samples on clk and is disabled while rst_n is low
`ifndef BYTE_RING_FIFO_CORE_MACROS_SVH
`define BYTE_RING_FIFO_CORE_MACROS_SVH

// same-cycle implication
`define BRF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ring fifo check failed");

// next-cycle implication
`define BRF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ring fifo check failed");

`endif

[design/brf_pkg.sv]
// ----------------------------------------------------------------------------
// brf_pkg
// shared constants, command codes, controller states and the control and
// status bundles between the ring fifo controller and its datapath
// ----------------------------------------------------------------------------
`default_nettype none

package brf_pkg;

  localparam int ADDR_W    = 10;
  localparam int DEPTH     = 1 << ADDR_W;
  localparam int CNT_W     = 10;
  localparam int MAX_BURST = 64;
  localparam int N_W       = 7;
  localparam int IDX_W     = 6;
  localparam int BYTE_W    = 8;
  localparam int CMD_W     = 3;

  typedef enum logic [CMD_W-1:0] {
    OP_PUSH    = 3'd0,
    OP_POP     = 3'd1,
    OP_PEEK    = 3'd2,
    OP_SKIP    = 3'd3,
    OP_RETRACT = 3'd4,
    OP_CLEAR   = 3'd5,
    OP_STATUS  = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic apply;
    logic start;
    logic emit;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t  op;
    logic burst_empty;
    logic run_last;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

[design/byte_ring_fifo_core.sv]
// A byte ring buffer of 1024 slots holding at most 1023 bytes. An item is
// taken, then executed in the next cycle; push, skip, retract, clear, status
// and a pop or peek with nothing to move give one result there, and a new item
// is taken only once the last has finished. A pop or peek of n bytes (clamped
// to 64 and to the bytes held) spends that execute cycle clamping and starting
// the first store read, then sends one byte per cycle while the output is free,
// paced by the registered read port of the byte store, which has one write port
// and one read port. An output register decouples the result side: a stalled
// result holds the block in place without losing anything. The store needs no
// clearing pass after reset; only written slots ever reach the output.
// ----------------------------------------------------------------------------
// byte_ring_fifo_core
// top level of the byte ring fifo: sequencer plus store and index datapath
// ----------------------------------------------------------------------------
`default_nettype none

module byte_ring_fifo_core (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire  [brf_pkg::CMD_W-1:0]   in_command,
  input  wire  [brf_pkg::BYTE_W-1:0]  in_data_byte,
  input  wire  [brf_pkg::N_W-1:0]     in_count,
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic [brf_pkg::BYTE_W-1:0]  out_byte,
  output logic                        out_byte_valid,
  output logic                        out_last,
  output logic [brf_pkg::N_W-1:0]     out_moved,
  output logic [brf_pkg::CNT_W-1:0]   out_used_count,
  output logic [brf_pkg::CNT_W-1:0]   out_free_count
);

  brf_pkg::ctrl_cmd_t cmd;
  brf_pkg::dp_stat_t  stat;

  brf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  brf_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_command     (in_command),
    .in_data_byte   (in_data_byte),
    .in_count       (in_count),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_last       (out_last),
    .out_moved      (out_moved),
    .out_used_count (out_used_count),
    .out_free_count (out_free_count)
  );

endmodule

`default_nettype wire

[design/brf_ctrl.sv]
// ----------------------------------------------------------------------------
// brf_ctrl
// sequencer for the ring fifo: takes an item, runs a single-result command
// or walks a pop/peek burst one byte per cycle under output backpressure
// ----------------------------------------------------------------------------
`default_nettype none

`include "byte_ring_fifo_core_macros.svh"

module brf_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  input  brf_pkg::dp_stat_t stat,
  output brf_pkg::ctrl_cmd_t cmd
);

  brf_pkg::state_t state_r, state_nxt;
  logic            is_burst;

  assign is_burst = (stat.op == brf_pkg::OP_POP) || (stat.op == brf_pkg::OP_PEEK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= brf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      brf_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = brf_pkg::ST_EXEC;
        end
      end
      brf_pkg::ST_EXEC: begin
        if (is_burst && !stat.burst_empty) begin
          state_nxt = brf_pkg::ST_EMIT;
        end else if (stat.out_free) begin
          state_nxt = brf_pkg::ST_IDLE;
        end
      end
      brf_pkg::ST_EMIT: begin
        if (stat.out_free && stat.run_last) begin
          state_nxt = brf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = brf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd         = '0;
    unique case (state_r)
      brf_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      brf_pkg::ST_EXEC: begin
        if (is_burst && !stat.burst_empty) begin
          cmd.start = 1'b1;
        end else begin
          cmd.apply = stat.out_free;
        end
      end
      brf_pkg::ST_EMIT: begin
        cmd.emit = stat.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  `BRF_ASSERT_IMP(a_one_cmd, 1'b1, $onehot0({cmd.capture, cmd.apply, cmd.start, cmd.emit}))

endmodule

`default_nettype wire

[design/brf_datapath.sv]
// ----------------------------------------------------------------------------
// brf_datapath
// byte store, front and rear indices, request clamp, burst counter and the
// output register of the ring fifo
// ----------------------------------------------------------------------------
`default_nettype none

`include "byte_ring_fifo_core_macros.svh"

module brf_datapath (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire  [brf_pkg::CMD_W-1:0]        in_command,
  input  wire  [brf_pkg::BYTE_W-1:0]       in_data_byte,
  input  wire  [brf_pkg::N_W-1:0]          in_count,
  input  brf_pkg::ctrl_cmd_t               cmd,
  output brf_pkg::dp_stat_t                stat,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [brf_pkg::BYTE_W-1:0]       out_byte,
  output logic                             out_byte_valid,
  output logic                             out_last,
  output logic [brf_pkg::N_W-1:0]          out_moved,
  output logic [brf_pkg::CNT_W-1:0]        out_used_count,
  output logic [brf_pkg::CNT_W-1:0]        out_free_count
);

  localparam logic [brf_pkg::CNT_W-1:0] CAPACITY = brf_pkg::CNT_W'(brf_pkg::DEPTH - 1);
  localparam logic [brf_pkg::N_W-1:0]   BURST_LIM = brf_pkg::N_W'(brf_pkg::MAX_BURST);

  logic [brf_pkg::BYTE_W-1:0] byte_store [brf_pkg::DEPTH];

  brf_pkg::op_t                 op_r;
  logic [brf_pkg::BYTE_W-1:0]   data_r;
  logic [brf_pkg::N_W-1:0]      count_r;
  logic [brf_pkg::ADDR_W-1:0]   front_r, front_nxt;
  logic [brf_pkg::ADDR_W-1:0]   rear_r, rear_nxt;
  logic [brf_pkg::N_W-1:0]      n_r;
  logic [brf_pkg::IDX_W-1:0]    idx_r, idx_nxt;
  logic [brf_pkg::CNT_W-1:0]    ustat_r;
  logic [brf_pkg::BYTE_W-1:0]   rd_data_r;

  logic                         out_valid_r, out_valid_nxt;
  logic [brf_pkg::BYTE_W-1:0]   out_byte_r;
  logic                         byte_valid_r;
  logic                         last_r;
  logic [brf_pkg::N_W-1:0]      moved_r;
  logic [brf_pkg::CNT_W-1:0]    used_out_r;

  logic [brf_pkg::CNT_W-1:0]    used;
  logic [brf_pkg::N_W-1:0]      req_lim;
  logic [brf_pkg::N_W-1:0]      n_clamp;
  logic                         full;
  logic                         out_free;
  logic                         run_last;
  logic [brf_pkg::ADDR_W-1:0]   rd_addr;
  logic [brf_pkg::ADDR_W-1:0]   wr_addr;
  logic                         wr_en;
  logic [brf_pkg::N_W-1:0]      res_moved;
  logic [brf_pkg::CNT_W-1:0]    res_used;

  // occupancy wraps naturally at the power-of-two depth
  assign used     = brf_pkg::CNT_W'(rear_r - front_r);
  assign full     = (used == CAPACITY);
  assign req_lim  = (count_r > BURST_LIM) ? BURST_LIM : count_r;
  assign n_clamp  = (brf_pkg::CNT_W'(req_lim) > used) ? brf_pkg::N_W'(used) : req_lim;
  assign out_free = !out_valid_r || out_ready;
  assign run_last = ((brf_pkg::N_W'(idx_r) + brf_pkg::N_W'(1)) == n_r);

  assign stat.op          = op_r;
  assign stat.burst_empty = (n_clamp == '0);
  assign stat.run_last    = run_last;
  assign stat.out_free    = out_free;

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.capture || cmd.start) begin
      idx_nxt = '0;
    end else if (cmd.emit) begin
      idx_nxt = idx_r + brf_pkg::IDX_W'(1);
    end
  end

  // read runs ahead on the next index so the registered byte matches idx_r
  assign rd_addr = front_r + brf_pkg::ADDR_W'(1) + brf_pkg::ADDR_W'(idx_nxt);
  assign wr_addr = rear_r + brf_pkg::ADDR_W'(1);
  assign wr_en   = cmd.apply && (op_r == brf_pkg::OP_PUSH) && !full;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      byte_store[wr_addr] <= data_r;
    end
    rd_data_r <= byte_store[rd_addr];
  end

  // single-result commands, and the front advance at the end of a pop burst
  always_comb begin
    front_nxt = front_r;
    rear_nxt  = rear_r;
    res_moved = '0;
    res_used  = used;
    if (cmd.apply) begin
      unique case (op_r)
        brf_pkg::OP_PUSH: begin
          if (!full) begin
            rear_nxt  = wr_addr;
            res_moved = brf_pkg::N_W'(1);
            res_used  = used + brf_pkg::CNT_W'(1);
          end
        end
        brf_pkg::OP_SKIP: begin
          front_nxt = front_r + brf_pkg::ADDR_W'(n_clamp);
          res_moved = n_clamp;
          res_used  = used - brf_pkg::CNT_W'(n_clamp);
        end
        brf_pkg::OP_RETRACT: begin
          rear_nxt  = rear_r - brf_pkg::ADDR_W'(n_clamp);
          res_moved = n_clamp;
          res_used  = used - brf_pkg::CNT_W'(n_clamp);
        end
        brf_pkg::OP_CLEAR: begin
          front_nxt = '0;
          rear_nxt  = '0;
          res_used  = '0;
        end
        default: begin
          res_used = used;
        end
      endcase
    end else if (cmd.emit && run_last && (op_r == brf_pkg::OP_POP)) begin
      front_nxt = front_r + brf_pkg::ADDR_W'(n_r);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.apply || cmd.emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      rear_r      <= '0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      front_r     <= front_nxt;
      rear_r      <= rear_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= brf_pkg::op_t'(in_command);
      data_r  <= in_data_byte;
      count_r <= in_count;
    end
    if (cmd.start) begin
      n_r     <= n_clamp;
      ustat_r <= (op_r == brf_pkg::OP_POP) ? used - brf_pkg::CNT_W'(n_clamp) : used;
    end
    if (cmd.apply) begin
      out_byte_r   <= '0;
      byte_valid_r <= 1'b0;
      last_r       <= 1'b1;
      moved_r      <= res_moved;
      used_out_r   <= res_used;
    end else if (cmd.emit) begin
      out_byte_r   <= rd_data_r;
      byte_valid_r <= 1'b1;
      last_r       <= run_last;
      moved_r      <= n_r;
      used_out_r   <= ustat_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_byte_valid = byte_valid_r;
  assign out_last       = last_r;
  assign out_moved      = moved_r;
  assign out_used_count = used_out_r;
  assign out_free_count = CAPACITY - used_out_r;

  `BRF_ASSERT_IMP(a_no_overwrite, cmd.apply || cmd.emit, out_free)
  `BRF_ASSERT_IMP(a_start_range, cmd.start, (n_clamp != '0) && (n_clamp <= BURST_LIM))
  `BRF_ASSERT_NXT(a_burst_used, cmd.emit && run_last, used == $past(ustat_r))

endmodule

`default_nettype wire
